@@ rtl/core/cqw_pkg.sv @@
package cqw_pkg;

	localparam int CAP_W = 7;
	localparam int DATA_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DEQ  = 2'd1,
		KIND_PEEK = 2'd2,
		KIND_SHOW = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SEND
	} state_t;

	typedef struct packed {
		logic    enq;
		logic    set_status;
		status_t status;
		logic    start;
		logic    capture;
		logic    cap_last;
		logic    pop;
		logic    step;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic final_word;
		logic out_last;
	} sts_t;

endpackage

@@ rtl/core/cqw_ram.sv @@
module cqw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/cqw_ctrl.sv @@
module cqw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [1:0]     s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  cqw_pkg::sts_t  sts,
	output cqw_pkg::cmd_t  cmd
);

	cqw_pkg::state_t state_q, state_d;
	cqw_pkg::kind_t  kind_q, kind_d, kind_in;

	assign kind_in = cqw_pkg::kind_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cqw_pkg::S_IDLE;
			kind_q  <= cqw_pkg::KIND_ENQ;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			cqw_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					kind_d = kind_in;
					if (kind_in == cqw_pkg::KIND_ENQ) begin
						cmd.set_status = 1'b1;
						if (sts.full) begin
							cmd.status = cqw_pkg::ST_FULL;
						end else begin
							cmd.status = cqw_pkg::ST_OK;
							cmd.enq    = 1'b1;
						end
						state_d = cqw_pkg::S_SEND;
					end else if (sts.empty) begin
						cmd.set_status = 1'b1;
						cmd.status     = cqw_pkg::ST_EMPTY;
						state_d        = cqw_pkg::S_SEND;
					end else begin
						cmd.start = 1'b1;
						state_d   = cqw_pkg::S_READ;
					end
				end
			end
			cqw_pkg::S_READ: begin
				cmd.capture  = 1'b1;
				cmd.cap_last = (kind_q != cqw_pkg::KIND_SHOW) || sts.final_word;
				cmd.pop      = (kind_q == cqw_pkg::KIND_DEQ);
				state_d      = cqw_pkg::S_SEND;
			end
			cqw_pkg::S_SEND: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (sts.out_last) begin
						state_d = cqw_pkg::S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = cqw_pkg::S_READ;
					end
				end
			end
			default: begin
				state_d = cqw_pkg::S_IDLE;
			end
		endcase
	end

	a_pop_only_on_deq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (kind_q == cqw_pkg::KIND_DEQ))
		else $error("pop outside dequeue");

endmodule

@@ rtl/core/cqw_dp.sv @@
module cqw_dp #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [cqw_pkg::DATA_W-1:0]     s_tdata,
	input  logic                           cfg_wen,
	input  logic [cqw_pkg::CAP_W-1:0]      cfg_wdata,
	input  cqw_pkg::cmd_t                  cmd,
	output cqw_pkg::sts_t                  sts,
	output logic [cqw_pkg::DATA_W-1:0]     m_tdata,
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	localparam int PW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [cqw_pkg::CAP_W-1:0] DEPTH_C = cqw_pkg::CAP_W'(DEPTH);

	logic [cqw_pkg::CAP_W-1:0]  cap_q, eff_cap;
	logic [PW-1:0]              rptr_q, wptr_q, walk_q, walk_next, raddr;
	logic [FW-1:0]              fill_q, rem_q;
	logic [cqw_pkg::DATA_W-1:0] rdata, out_data_q;
	cqw_pkg::status_t           out_status_q;
	logic                       out_last_q;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos,
		input logic [cqw_pkg::CAP_W-1:0] cap);
		logic [cqw_pkg::CAP_W-1:0] n;
		n = cqw_pkg::CAP_W'(pos) + cqw_pkg::CAP_W'(1);
		if (n >= cap) begin
			return '0;
		end
		return n[PW-1:0];
	endfunction

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = cqw_pkg::CAP_W'(1);
		end else if (cap_q > DEPTH_C) begin
			eff_cap = DEPTH_C;
		end else begin
			eff_cap = cap_q;
		end
	end

	assign walk_next = advance(walk_q, eff_cap);
	assign raddr     = cmd.start ? rptr_q : walk_next;

	cqw_ram #(
		.WIDTH(cqw_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.enq),
		.waddr(wptr_q),
		.wdata(s_tdata),
		.re   (cmd.start | cmd.step),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= cqw_pkg::CAP_RESET;
			rptr_q     <= '0;
			wptr_q     <= '0;
			fill_q     <= '0;
			walk_q     <= '0;
			rem_q      <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.enq) begin
				wptr_q <= advance(wptr_q, eff_cap);
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.pop) begin
				rptr_q <= advance(rptr_q, eff_cap);
				fill_q <= fill_q - FW'(1);
			end
			if (cmd.start) begin
				walk_q <= rptr_q;
				rem_q  <= fill_q;
			end
			if (cmd.step) begin
				walk_q <= walk_next;
				rem_q  <= rem_q - FW'(1);
			end
			if (cmd.set_status) begin
				out_last_q <= 1'b1;
			end
			if (cmd.capture) begin
				out_last_q <= cmd.cap_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_status) begin
			out_status_q <= cmd.status;
			out_data_q   <= '0;
		end
		if (cmd.capture) begin
			out_status_q <= cqw_pkg::ST_OK;
			out_data_q   <= rdata;
		end
	end

	assign sts.full       = cqw_pkg::CAP_W'(fill_q) >= eff_cap;
	assign sts.empty      = (fill_q == '0);
	assign sts.final_word = (rem_q == FW'(1));
	assign sts.out_last   = out_last_q;

	assign m_tdata = out_data_q;
	assign m_tuser = out_status_q;
	assign m_tlast = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cqw_pkg::CAP_W'(fill_q) <= DEPTH_C)
		else $error("fill count above depth");

	a_no_enq_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |-> !sts.full)
		else $error("write into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.empty)
		else $error("pop from empty queue");

	a_step_has_words: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (rem_q > FW'(1)))
		else $error("walk past last stored word");

endmodule

@@ rtl/core/circular_queue_with_walk.sv @@
// Enqueue, full and empty results: m_tvalid rises in the cycle after the input transaction.
// Dequeue and peek: the transaction starts a RAM read, READ captures the word, and SEND raises m_tvalid.
// Display: after each word is taken, the next word is read from RAM, captured in READ and offered in SEND.
// A new input transaction is taken the cycle after the final result is taken.
// Reset clears positions and fill count and sets capacity to 64; storage is not cleared.
module circular_queue_with_walk #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // data_in
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // data_out
	output logic [1:0]  m_tuser,   // status
	output logic        m_tlast,
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata  // queue_capacity
);

	cqw_pkg::cmd_t cmd;
	cqw_pkg::sts_t sts;

	cqw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cqw_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ test/circular_queue_with_walk_test.sv @@
module circular_queue_with_walk_test;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		cqw_pkg::kind_t kind;
		logic [31:0]    word;
	} request_t;

	typedef struct {
		cqw_pkg::status_t status;
		logic [31:0]      word;
		logic             last;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_wen;
	logic [6:0]  cfg_wdata;

	request_t    pending_requests[$];
	reply_t      expected_replies[$];
	request_t    next_request;
	reply_t      want;

	logic [31:0] queue_words [0:DEPTH-1];
	logic [5:0]  head_pos;
	logic [5:0]  tail_pos;
	logic [6:0]  word_count;
	logic [6:0]  capacity_reg;

	int sent_count;
	int taken_count;
	int mismatches;
	int stall_cycles;
	int idle_pct;
	bit settle;

	circular_queue_with_walk #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int effective_depth();
		if (capacity_reg == 0)
			return 1;
		if (capacity_reg > DEPTH)
			return DEPTH;
		return capacity_reg;
	endfunction

	function automatic logic [5:0] wrap_step(logic [5:0] pos);
		int n;
		n = pos + 1;
		if (n >= effective_depth())
			n = 0;
		return n[5:0];
	endfunction

	task automatic add_reply(cqw_pkg::status_t status, logic [31:0] word, logic last);
		reply_t r;
		r.status = status;
		r.word = word;
		r.last = last;
		expected_replies.push_back(r);
	endtask

	task automatic apply_queue_op(cqw_pkg::kind_t op, logic [31:0] word);
		logic [5:0] pos;
		int n;
		if (op == cqw_pkg::KIND_ENQ) begin
			if (word_count >= effective_depth()) begin
				add_reply(cqw_pkg::ST_FULL, 32'd0, 1'b1);
			end else begin
				queue_words[tail_pos] = word;
				tail_pos = wrap_step(tail_pos);
				word_count++;
				add_reply(cqw_pkg::ST_OK, 32'd0, 1'b1);
			end
		end else if (word_count == 0) begin
			add_reply(cqw_pkg::ST_EMPTY, 32'd0, 1'b1);
		end else if (op == cqw_pkg::KIND_DEQ) begin
			add_reply(cqw_pkg::ST_OK, queue_words[head_pos], 1'b1);
			head_pos = wrap_step(head_pos);
			word_count--;
		end else if (op == cqw_pkg::KIND_PEEK) begin
			add_reply(cqw_pkg::ST_OK, queue_words[head_pos], 1'b1);
		end else begin
			n = (word_count > DEPTH) ? DEPTH : word_count;
			pos = head_pos;
			for (int k = 0; k < n; k++) begin
				add_reply(cqw_pkg::ST_OK, queue_words[pos], k + 1 == n);
				pos = wrap_step(pos);
			end
		end
	endtask

	task automatic add_request(cqw_pkg::kind_t kind, logic [31:0] word);
		request_t r;
		r.kind = kind;
		r.word = word;
		pending_requests.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || sent_count != taken_count ||
				expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [6:0] value);
		wait_idle();
		@(negedge clk);
		cfg_wdata <= value;
		cfg_wen <= 1'b1;
		@(negedge clk);
		cfg_wen <= 1'b0;
		capacity_reg = value;
	endtask

	task automatic drain_queue();
		wait_idle();
		repeat (word_count) add_request(cqw_pkg::KIND_DEQ, $urandom);
	endtask

	task automatic add_traffic(int total);
		int added;
		int len;
		int r;
		added = 0;
		while (added < total) begin
			case ($urandom_range(3))
				0: begin
					len = $urandom_range(1, effective_depth() + 2);
					repeat (len) add_request(cqw_pkg::KIND_ENQ, $urandom);
				end
				1: begin
					len = $urandom_range(1, effective_depth() + 2);
					repeat (len) add_request(cqw_pkg::KIND_DEQ, $urandom);
				end
				default: begin
					len = $urandom_range(4, 12);
					repeat (len) begin
						r = $urandom_range(99);
						if (r < 40)
							add_request(cqw_pkg::KIND_ENQ, $urandom);
						else if (r < 65)
							add_request(cqw_pkg::KIND_DEQ, $urandom);
						else if (r < 80)
							add_request(cqw_pkg::KIND_PEEK, $urandom);
						else
							add_request(cqw_pkg::KIND_SHOW, $urandom);
					end
				end
			endcase
			added += len;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && sent_count == taken_count) begin
			if (settle && expected_replies.size() == 0)
				settle = 1'b0;
			if (!settle && pending_requests.size() != 0 &&
					$urandom_range(99) >= idle_pct) begin
				next_request = pending_requests.pop_front();
				s_tdata <= next_request.word;
				s_tuser <= next_request.kind;
				s_tvalid <= 1'b1;
				sent_count++;
				if ($urandom_range(49) == 0)
					settle = 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				taken_count++;
				apply_queue_op(cqw_pkg::kind_t'(s_tuser), s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: status %0d data %h last %b",
							m_tuser, m_tdata, m_tlast);
				end else begin
					want = expected_replies.pop_front();
					if (m_tuser !== want.status || m_tdata !== want.word ||
							m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected status %0d data %h last %b, got status %0d data %h last %b",
								want.status, want.word, want.last, m_tuser, m_tdata, m_tlast);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		head_pos = '0;
		tail_pos = '0;
		word_count = '0;
		capacity_reg = cqw_pkg::CAP_RESET;
		sent_count = 0;
		taken_count = 0;
		mismatches = 0;
		stall_cycles = 0;
		idle_pct = 12;
		settle = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_request(cqw_pkg::KIND_DEQ, $urandom);
		add_request(cqw_pkg::KIND_PEEK, $urandom);
		add_request(cqw_pkg::KIND_SHOW, $urandom);
		add_request(cqw_pkg::KIND_ENQ, 32'h8000_0000);
		add_request(cqw_pkg::KIND_ENQ, 32'h7fff_ffff);
		add_request(cqw_pkg::KIND_ENQ, 32'hffff_ffff);
		add_request(cqw_pkg::KIND_ENQ, 32'h0000_0000);
		add_request(cqw_pkg::KIND_PEEK, $urandom);
		add_request(cqw_pkg::KIND_SHOW, $urandom);
		repeat (5) add_request(cqw_pkg::KIND_DEQ, $urandom);

		set_capacity(7'd0);
		add_request(cqw_pkg::KIND_ENQ, $urandom);
		add_request(cqw_pkg::KIND_ENQ, $urandom);
		add_request(cqw_pkg::KIND_PEEK, $urandom);
		add_request(cqw_pkg::KIND_SHOW, $urandom);
		add_request(cqw_pkg::KIND_DEQ, $urandom);
		add_request(cqw_pkg::KIND_ENQ, $urandom);
		add_request(cqw_pkg::KIND_SHOW, $urandom);
		add_request(cqw_pkg::KIND_DEQ, $urandom);

		set_capacity(7'd127);
		add_traffic(70);
		drain_queue();
		set_capacity(7'd1);
		add_traffic(40);
		drain_queue();
		set_capacity(7'd64);
		idle_pct = 0;
		add_traffic(70);
		drain_queue();
		wait_idle();
		idle_pct = 12;
		set_capacity(7'd3);
		add_traffic(50);
		drain_queue();
		set_capacity(7'($urandom_range(4, 63)));
		add_traffic(60);
		drain_queue();
		set_capacity(7'd2);
		add_traffic(40);

		wait_idle();
		repeat (20) @(posedge clk);
		if (expected_replies.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
